[rtl/ippf_pkg.sv]
// ----------------------------------------------------------------------------
// ippf_pkg: shared types and constants for the IPv4 pair policy filter
// Table sizes, action and cause codes, and the front-to-back queue item.
// ----------------------------------------------------------------------------
`default_nettype none

package ippf_pkg;

  localparam int RULE_CAP = 4096;
  localparam int ISO_CAP  = 1024;

  localparam int RULE_AW = (RULE_CAP > 1) ? $clog2(RULE_CAP) : 1;
  localparam int ISO_AW  = (ISO_CAP > 1) ? $clog2(ISO_CAP) : 1;
  localparam int RULE_CW = $clog2(RULE_CAP + 1);
  localparam int ISO_CW  = $clog2(ISO_CAP + 1);
  localparam int SCAN_W  = (RULE_CW > ISO_CW) ? RULE_CW : ISO_CW;

  localparam logic [2:0] ACT_CLASSIFY  = 3'd0;
  localparam logic [2:0] ACT_WRITE     = 3'd1;
  localparam logic [2:0] ACT_DELETE    = 3'd2;
  localparam logic [2:0] ACT_ISOLATE   = 3'd3;
  localparam logic [2:0] ACT_UNISOLATE = 3'd4;

  localparam logic [2:0] CAUSE_NONE      = 3'd0;
  localparam logic [2:0] CAUSE_TRUNC     = 3'd1;
  localparam logic [2:0] CAUSE_MALFORMED = 3'd2;
  localparam logic [2:0] CAUSE_DENY      = 3'd3;
  localparam logic [2:0] CAUSE_ISOLATED  = 3'd4;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
  localparam logic [15:0] IP_MIN_END     = 16'd34;

  typedef enum logic [1:0] {
    HDR_PASS,
    HDR_TRUNC,
    HDR_MALFORMED,
    HDR_LOOKUP
  } hdr_code_t;

  typedef struct packed {
    logic [2:0]  action;
    hdr_code_t   hdr;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  value;
  } q_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_LRD,
    ST_LWR,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

[rtl/ippf_front.sv]
// ----------------------------------------------------------------------------
// ippf_front: input acceptance, header checks and two-item queue
// Header sanity is decided on entry; the back end only sees a short code.
// ----------------------------------------------------------------------------
`default_nettype none

module ippf_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  input  wire  [2:0]            s_tuser,
  input  wire  [143:0]          s_tdata,
  output logic                  q_valid,
  output ippf_pkg::q_item_t     q_item,
  input  wire                   q_pop
);
  import ippf_pkg::*;

  logic [15:0] frame_len, linear_len, ethertype, total_length;
  logic [7:0]  version_ihl;
  logic [16:0] hlen, hdr_end, pkt_end;
  logic        malformed;
  hdr_code_t   hdr;
  q_item_t     entry;

  q_item_t     qmem [2];
  logic        wptr, rptr;
  logic [1:0]  fill;
  logic        push;

  assign frame_len    = s_tdata[15:0];
  assign linear_len   = s_tdata[31:16];
  assign ethertype    = s_tdata[47:32];
  assign version_ihl  = s_tdata[55:48];
  assign total_length = s_tdata[71:56];

  assign hlen    = {11'd0, version_ihl[3:0], 2'b00};
  assign hdr_end = {1'b0, ETH_HDR_BYTES} + hlen;
  assign pkt_end = {1'b0, ETH_HDR_BYTES} + {1'b0, total_length};

  assign malformed = (version_ihl[7:4] != 4'd4) || (hlen < 17'd20) ||
                     (hdr_end > {1'b0, linear_len}) ||
                     ({1'b0, total_length} < hlen) ||
                     (pkt_end > {1'b0, frame_len});

  always_comb begin
    priority if (linear_len < ETH_HDR_BYTES) hdr = HDR_PASS;
    else if (ethertype != ETHERTYPE_IPV4)    hdr = HDR_PASS;
    else if (linear_len < IP_MIN_END)        hdr = HDR_TRUNC;
    else if (malformed)                      hdr = HDR_MALFORMED;
    else                                     hdr = HDR_LOOKUP;
  end

  always_comb begin
    entry.action = s_tuser;
    entry.hdr    = hdr;
    entry.src    = s_tdata[103:72];
    entry.dst    = s_tdata[135:104];
    entry.value  = s_tdata[143:136];
  end

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = qmem[rptr];

  always_ff @(posedge clk) begin
    if (push) qmem[wptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
  assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop && fill == 2'd1) |=> !s_tready)
    else $error("queue not full after filling");

endmodule

`default_nettype wire

[rtl/ippf_back.sv]
// ----------------------------------------------------------------------------
// ippf_back: table engine and result register
// Rule and isolation stores are kept packed; a scan walks the valid entries,
// deletes move the last entry into the hole.
// ----------------------------------------------------------------------------
`default_nettype none

module ippf_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   q_valid,
  input  ippf_pkg::q_item_t     q_item,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic [7:0]            m_tdata
);
  import ippf_pkg::*;

  logic [71:0]  rule_mem [RULE_CAP];
  logic [31:0]  iso_mem  [ISO_CAP];
  logic [71:0]  rule_q;
  logic [31:0]  iso_q;
  logic [RULE_AW-1:0] rule_ra, rule_wa;
  logic [ISO_AW-1:0]  iso_ra, iso_wa;
  logic [71:0]  rule_wd;
  logic [31:0]  iso_wd;
  logic         rule_we, iso_we;

  state_t state, state_next;
  q_item_t cur;
  logic [SCAN_W-1:0]  idx, scan_lim;
  logic [RULE_CW-1:0] rc, rc_m1;
  logic [ISO_CW-1:0]  ic, ic_m1;
  logic         rhit, ihit;
  logic [RULE_AW-1:0] rpos;
  logic [ISO_AW-1:0]  ipos;
  logic [7:0]   rval;
  logic         res_verdict, res_status;
  logic [2:0]   res_cause;
  logic         v_next, s_next;
  logic [2:0]   c_next;
  logic         rc_inc, rc_dec, ic_inc, ic_dec;
  logic         out_free, early;

  assign rc_m1    = rc - 1'b1;
  assign ic_m1    = ic - 1'b1;
  assign scan_lim = (SCAN_W'(rc) > SCAN_W'(ic)) ? SCAN_W'(rc) : SCAN_W'(ic);
  assign out_free = !m_tvalid || m_tready;
  assign early    = (q_item.action == ACT_CLASSIFY && q_item.hdr != HDR_LOOKUP) ||
                    (q_item.action > ACT_UNISOLATE);

  assign rule_ra = (state == ST_LRD) ? rc_m1[RULE_AW-1:0] : idx[RULE_AW-1:0];
  assign iso_ra  = (state == ST_LRD) ? ic_m1[ISO_AW-1:0] : idx[ISO_AW-1:0];

  always_ff @(posedge clk) begin
    rule_q <= rule_mem[rule_ra];
    iso_q  <= iso_mem[iso_ra];
    if (rule_we) rule_mem[rule_wa] <= rule_wd;
    if (iso_we) iso_mem[iso_wa] <= iso_wd;
  end

  always_comb begin
    state_next = state;
    q_pop   = 1'b0;
    rule_we = 1'b0;
    iso_we  = 1'b0;
    rule_wa = rpos;
    iso_wa  = ipos;
    rule_wd = {cur.src, cur.dst, cur.value};
    iso_wd  = cur.src;
    rc_inc = 1'b0; rc_dec = 1'b0; ic_inc = 1'b0; ic_dec = 1'b0;
    v_next = 1'b0; c_next = CAUSE_NONE; s_next = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_next = early ? ST_FIN : ST_RD;
        end
      end
      ST_RD: begin
        if (idx < scan_lim) begin
          state_next = ST_CMP;
        end else begin
          state_next = ST_FIN;
          unique case (cur.action)
            ACT_CLASSIFY: begin
              if (rhit && rval == 8'd0) begin
                v_next = 1'b1; c_next = CAUSE_DENY;
              end else if (ihit && !(rhit && rval == 8'd1)) begin
                v_next = 1'b1; c_next = CAUSE_ISOLATED;
              end
            end
            ACT_WRITE: begin
              if (rhit) begin
                rule_we = 1'b1;
              end else if (rc == RULE_CW'(RULE_CAP)) begin
                s_next = 1'b1;
              end else begin
                rule_we = 1'b1;
                rule_wa = rc[RULE_AW-1:0];
                rc_inc  = 1'b1;
              end
            end
            ACT_DELETE: begin
              if (rhit) begin
                if (rpos == rc_m1[RULE_AW-1:0]) rc_dec = 1'b1;
                else state_next = ST_LRD;
              end
            end
            ACT_ISOLATE: begin
              if (!ihit) begin
                if (ic == ISO_CW'(ISO_CAP)) begin
                  s_next = 1'b1;
                end else begin
                  iso_we = 1'b1;
                  iso_wa = ic[ISO_AW-1:0];
                  ic_inc = 1'b1;
                end
              end
            end
            ACT_UNISOLATE: begin
              if (ihit) begin
                if (ipos == ic_m1[ISO_AW-1:0]) ic_dec = 1'b1;
                else state_next = ST_LRD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CMP: state_next = ST_RD;
      ST_LRD: state_next = ST_LWR;
      ST_LWR: begin
        state_next = ST_FIN;
        if (cur.action == ACT_DELETE) begin
          rule_we = 1'b1;
          rule_wd = rule_q;
          rc_dec  = 1'b1;
        end else begin
          iso_we = 1'b1;
          iso_wd = iso_q;
          ic_dec = 1'b1;
        end
      end
      ST_FIN: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc       <= '0;
      ic       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      rc <= rc + RULE_CW'(rc_inc) - RULE_CW'(rc_dec);
      ic <= ic + ISO_CW'(ic_inc) - ISO_CW'(ic_dec);
      if (state == ST_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tready)               m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur  <= q_item;
      idx  <= '0;
      rhit <= 1'b0;
      ihit <= 1'b0;
      res_verdict <= 1'b0;
      res_status  <= 1'b0;
      res_cause   <= CAUSE_NONE;
      if (q_item.action == ACT_CLASSIFY && q_item.hdr == HDR_TRUNC) begin
        res_verdict <= 1'b1; res_cause <= CAUSE_TRUNC;
      end
      if (q_item.action == ACT_CLASSIFY && q_item.hdr == HDR_MALFORMED) begin
        res_verdict <= 1'b1; res_cause <= CAUSE_MALFORMED;
      end
    end
    if (state == ST_RD && idx >= scan_lim) begin
      res_verdict <= v_next;
      res_cause   <= c_next;
      res_status  <= s_next;
    end
    if (state == ST_CMP) begin
      idx <= idx + 1'b1;
      if (SCAN_W'(rc) > idx && rule_q[71:8] == {cur.src, cur.dst}) begin
        rhit <= 1'b1;
        rpos <= idx[RULE_AW-1:0];
        rval <= rule_q[7:0];
      end
      if (SCAN_W'(ic) > idx && iso_q == cur.src) begin
        ihit <= 1'b1;
        ipos <= idx[ISO_AW-1:0];
      end
    end
    if (state == ST_FIN && out_free)
      m_tdata <= {3'b000, res_status, res_cause, res_verdict};
  end

  assert property (@(posedge clk) disable iff (rst) rc <= RULE_CW'(RULE_CAP))
    else $error("rule count beyond capacity");
  assert property (@(posedge clk) disable iff (rst) ic <= ISO_CW'(ISO_CAP))
    else $error("isolation count beyond capacity");
  assert property (@(posedge clk) disable iff (rst) q_pop |=> state != ST_IDLE)
    else $error("item taken but engine idle");
  assert property (@(posedge clk) disable iff (rst)
    (rule_we && iso_we) == 1'b0)
    else $error("both stores written in one cycle");

endmodule

`default_nettype wire

[rtl/ipv4_pair_policy_filter_unit.sv]
// ----------------------------------------------------------------------------
// ipv4_pair_policy_filter_unit: source/destination IPv4 policy filter
// Packet classification against a pair rule table and isolated-source set.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser carries the action (classify, write rule, delete
// rule, isolate, unisolate); tdata carries the header summary and keys.
// Output stream m_*: one item per input item with verdict, drop cause and
// table status. Items come out in input order.
// A two-item queue follows header checking, so input is taken while the
// table engine works. Packets settled by header checks, and unknown
// actions, skip the scan. Any other item scans both stores up to the
// larger fill count; the scan over the one-read-port rule and isolation
// memories sets the rate.
// Reset empties both stores at once through their fill counts; no clearing
// pass is needed. When m_tready is low the result register holds its item,
// the engine waits in its final step and the queue then fills and stalls
// the input.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_pair_policy_filter_unit (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // action[2:0]
  input  wire  [2:0]   s_tuser,
  // frame_len, linear_len, ethertype, version_ihl, total_length,
  // src_addr, dst_addr, rule_value
  input  wire  [143:0] s_tdata,
  output logic         m_tvalid,
  input  wire          m_tready,
  // verdict, drop_cause[2:0], op_status, zero pad[2:0]
  output logic [7:0]   m_tdata
);
  import ippf_pkg::*;

  logic    q_valid, q_pop;
  q_item_t q_item;

  ippf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  ippf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
